/* rtl/cld_pkg.sv */
// Shared types, key codes and result codes for the console line discipline.
// No dependencies; every other file refers to this package by scoped names.
package cld_pkg;

  localparam int RING_DEPTH = 128;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int PTR_W      = SLOT_W + 1;

  localparam logic [7:0] KEY_NUL  = 8'h00;
  localparam logic [7:0] KEY_EOF  = 8'h04;
  localparam logic [7:0] KEY_BS   = 8'h08;
  localparam logic [7:0] KEY_LF   = 8'h0A;
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_DUMP = 8'h10;
  localparam logic [7:0] KEY_KILL = 8'h15;
  localparam logic [7:0] KEY_DEL  = 8'h7F;

  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_CHAR  = 2'd1;
  localparam logic [1:0] ECHO_ERASE = 2'd2;

  localparam logic [1:0] RS_NONE  = 2'd0;
  localparam logic [1:0] RS_BYTE  = 2'd1;
  localparam logic [1:0] RS_EMPTY = 2'd2;
  localparam logic [1:0] RS_EOF   = 2'd3;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic       action;
    logic [7:0] key_code;
    logic       first_of_read;
  } cmd_t;

  typedef struct packed {
    logic [1:0] echo_kind;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_ready;
    logic       dump_request;
    logic [1:0] read_status;
    logic [7:0] read_byte;
    logic       end_of_line;
  } result_t;

  typedef struct packed {
    ptr_t rd;
    ptr_t cm;
    ptr_t ed;
  } ptrs_t;

  typedef struct packed {
    logic       en;
    slot_t      addr;
    logic [7:0] data;
  } mem_wr_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // erase count clamps at 255 for deep rings
  function automatic logic [7:0] sat8(input ptr_t n);
    logic [15:0] w;
    w = 16'(n);
    return (w > 16'd255) ? 8'hFF : w[7:0];
  endfunction

endpackage

/* rtl/console_line_discipline.sv */
// Console line discipline top level: command port, pointer registers, control.
// Depends on cld_pkg, cld_ring_ram and cld_step.
//
// Usage:
//  - A command beat (cmd) is taken on a rising edge with start high and busy
//    low. cmd.action selects a keystroke (key_code) or a one-byte read
//    (first_of_read marks the first byte of a read call).
//  - Every command gives exactly one result beat on result, shown for one
//    cycle with done high. The receiver cannot stall; it must take it.
//  - Timing: the command edge also launches the ring read at the read
//    pointer; the next cycle (busy high) decides the action, writes the ring
//    and updates the pointers; the result appears in the cycle after that.
//    The ring memory has registered read data; a new command is taken only
//    after the decide cycle of the one before it.
//    busy is low while a result is shown, so the next command overlaps it.
//  - Reset (rst, synchronous) empties the ring by clearing all three
//    pointers; the ring contents are left as they are and are never read
//    before being written.
//  - RING_DEPTH in the package must be a power of two.
module console_line_discipline (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cld_pkg::cmd_t    cmd,
  output logic             done,
  output cld_pkg::result_t result
);

  cld_pkg::state_t  state;
  cld_pkg::state_t  state_next;
  cld_pkg::cmd_t    item;
  cld_pkg::ptrs_t   ptrs;
  cld_pkg::ptrs_t   ptrs_next;
  cld_pkg::mem_wr_t wr;
  cld_pkg::mem_wr_t wr_gated;
  cld_pkg::result_t res;
  logic [7:0]       rd_data;
  logic             accept;

  assign accept = start && !busy;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cld_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    case (state)
      cld_pkg::ST_IDLE: begin
        if (start) begin
          state_next = cld_pkg::ST_EXEC;
        end
      end
      cld_pkg::ST_EXEC: begin
        busy       = 1'b1;
        state_next = cld_pkg::ST_IDLE;
      end
      default: state_next = cld_pkg::ST_IDLE;
    endcase
  end

  // command beat held for the decide cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= cmd;
    end
  end

  // pointers and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      ptrs <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == cld_pkg::ST_EXEC);
      if (state == cld_pkg::ST_EXEC) begin
        ptrs <= ptrs_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == cld_pkg::ST_EXEC) begin
      result <= res;
    end
  end

  // the ring is only written in the decide cycle; a read launched at the
  // next accept therefore always sees the finished write
  always_comb begin
    wr_gated    = wr;
    wr_gated.en = wr.en && (state == cld_pkg::ST_EXEC);
  end

  cld_ring_ram u_ram (
    .clk     (clk),
    .wr      (wr_gated),
    .rd_en   (accept),
    .rd_addr (ptrs.rd[cld_pkg::SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  cld_step u_step (
    .item      (item),
    .rd_data   (rd_data),
    .ptrs      (ptrs),
    .ptrs_next (ptrs_next),
    .wr        (wr),
    .res       (res)
  );

  // a result beat only follows a decide cycle
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == cld_pkg::ST_EXEC))
    else $error("result beat without a decide cycle");

  // committed text never exceeds typed text, and the ring never overfills
  a_ptr_order: assert property (@(posedge clk) disable iff (rst)
    (cld_pkg::ptr_t'(ptrs.ed - ptrs.rd) <= cld_pkg::ptr_t'(cld_pkg::RING_DEPTH)) &&
    (cld_pkg::ptr_t'(ptrs.cm - ptrs.rd) <= cld_pkg::ptr_t'(ptrs.ed - ptrs.rd)))
    else $error("ring pointers out of order");

  // a returned byte consumes exactly one ring slot
  a_byte_advances: assert property (@(posedge clk) disable iff (rst)
    (done && result.read_status == cld_pkg::RS_BYTE) |->
      (ptrs.rd == cld_pkg::ptr_t'($past(ptrs.rd) + 1'b1)))
    else $error("read pointer did not advance on a returned byte");

  // an empty report leaves every pointer alone
  a_empty_stable: assert property (@(posedge clk) disable iff (rst)
    (done && result.read_status == cld_pkg::RS_EMPTY) |-> (ptrs == $past(ptrs)))
    else $error("pointers moved on an empty read");

endmodule

/* rtl/cld_ring_ram.sv */
// Byte ring storage: one write port, one read port, registered read data.
// Depends on cld_pkg for the slot width and write beat struct.
module cld_ring_ram (
  input  logic            clk,
  input  cld_pkg::mem_wr_t wr,
  input  logic            rd_en,
  input  cld_pkg::slot_t  rd_addr,
  output logic [7:0]      rd_data
);

  logic [7:0] mem [cld_pkg::RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/cld_step.sv */
// Edit and read decision logic: next pointers, ring write and result beat.
// Depends on cld_pkg; the stored byte at the read pointer arrives from the ram.
module cld_step (
  input  cld_pkg::cmd_t    item,
  input  logic [7:0]       rd_data,
  input  cld_pkg::ptrs_t   ptrs,
  output cld_pkg::ptrs_t   ptrs_next,
  output cld_pkg::mem_wr_t wr,
  output cld_pkg::result_t res
);

  cld_pkg::ptr_t   fill;
  cld_pkg::ptr_t   pend;
  cld_pkg::ptr_t   ed_inc;
  logic [7:0]      ch;

  assign fill   = cld_pkg::ptr_t'(ptrs.ed - ptrs.rd);
  assign pend   = cld_pkg::ptr_t'(ptrs.ed - ptrs.cm);
  assign ed_inc = cld_pkg::ptr_t'(ptrs.ed + 1'b1);
  assign ch     = (item.key_code == cld_pkg::KEY_CR) ? cld_pkg::KEY_LF : item.key_code;

  always_comb begin
    ptrs_next = ptrs;
    wr.en     = 1'b0;
    wr.addr   = ptrs.ed[cld_pkg::SLOT_W-1:0];
    wr.data   = ch;
    res       = '0;
    if (item.action == cld_pkg::ACT_KEY) begin
      case (item.key_code)
        cld_pkg::KEY_NUL: ;
        cld_pkg::KEY_DUMP: res.dump_request = 1'b1;
        cld_pkg::KEY_KILL: begin
          if (pend != '0) begin
            ptrs_next.ed    = ptrs.cm;
            res.echo_kind   = cld_pkg::ECHO_ERASE;
            res.erase_count = cld_pkg::sat8(pend);
          end
        end
        cld_pkg::KEY_BS, cld_pkg::KEY_DEL: begin
          if (pend != '0) begin
            ptrs_next.ed    = cld_pkg::ptr_t'(ptrs.ed - 1'b1);
            res.echo_kind   = cld_pkg::ECHO_ERASE;
            res.erase_count = 8'd1;
          end
        end
        default: begin
          if (fill < cld_pkg::ptr_t'(cld_pkg::RING_DEPTH)) begin
            wr.en         = 1'b1;
            ptrs_next.ed  = ed_inc;
            res.echo_kind = cld_pkg::ECHO_CHAR;
            res.echo_char = ch;
            // newline, end of file or a full ring makes the text readable
            if (ch == cld_pkg::KEY_LF || ch == cld_pkg::KEY_EOF ||
                cld_pkg::ptr_t'(ed_inc - ptrs.rd) == cld_pkg::ptr_t'(cld_pkg::RING_DEPTH)) begin
              ptrs_next.cm   = ed_inc;
              res.line_ready = 1'b1;
            end
          end
        end
      endcase
    end else begin
      if (ptrs.rd == ptrs.cm) begin
        res.read_status = cld_pkg::RS_EMPTY;
      end else if (rd_data == cld_pkg::KEY_EOF) begin
        res.read_status = cld_pkg::RS_EOF;
        if (item.first_of_read) begin
          ptrs_next.rd = cld_pkg::ptr_t'(ptrs.rd + 1'b1);
        end
      end else begin
        ptrs_next.rd    = cld_pkg::ptr_t'(ptrs.rd + 1'b1);
        res.read_status = cld_pkg::RS_BYTE;
        res.read_byte   = rd_data;
        res.end_of_line = (rd_data == cld_pkg::KEY_LF);
      end
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for console_line_discipline: keystroke and read beats
// in, one result beat out per command, checked against an in-bench line editor.
// Depends on cld_pkg and the console_line_discipline RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with neither an accepted command nor a result before giving up.
  // A healthy run never goes quiet for longer than the longest sender gap
  // plus the latency of one command, so this leaves a wide margin.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 200;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  cld_pkg::cmd_t    cmd;
  logic             done;
  cld_pkg::result_t result;

  console_line_discipline dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Line editor mirror: our own copy of the byte ring and the three pointers.
  // Pointers run modulo 2*RING_DEPTH (the natural wrap of ptr_t), so full and
  // empty are told apart by the difference, and the slot is the low bits.
  // ---------------------------------------------------------------------------
  logic [7:0]    ring_copy [cld_pkg::RING_DEPTH];
  cld_pkg::ptr_t rd_p = '0;
  cld_pkg::ptr_t cm_p = '0;
  cld_pkg::ptr_t ed_p = '0;

  cld_pkg::result_t due_results [$];   // one expected result beat per accepted command

  int         n_sent, n_keys, n_reads, n_checked;
  int         n_lines, n_bytes, n_eofs, mismatches;
  int         idle_cycles;
  logic       quiet;             // no sender gaps while set
  cld_pkg::result_t want;

  function automatic cld_pkg::result_t line_editor_step(input cld_pkg::cmd_t c);
    cld_pkg::result_t r;
    logic [7:0]       k;
    cld_pkg::ptr_t    n;
    r = '0;
    if (c.action == cld_pkg::ACT_KEY) begin
      k = c.key_code;
      if (k == cld_pkg::KEY_DUMP) begin
        r.dump_request = 1'b1;
      end else if (k == cld_pkg::KEY_KILL) begin
        // drop the whole uncommitted tail
        n = ed_p - cm_p;
        if (n != '0) begin
          ed_p          = cm_p;
          r.echo_kind   = cld_pkg::ECHO_ERASE;
          r.erase_count = (n > 255) ? 8'hFF : 8'(n);
        end
      end else if (k == cld_pkg::KEY_BS || k == cld_pkg::KEY_DEL) begin
        if (ed_p != cm_p) begin
          ed_p          = ed_p - 1'b1;
          r.echo_kind   = cld_pkg::ECHO_ERASE;
          r.erase_count = 8'd1;
        end
      end else if (k != cld_pkg::KEY_NUL) begin
        n = ed_p - rd_p;
        // a full ring swallows the key without any echo
        if (n < cld_pkg::RING_DEPTH) begin
          if (k == cld_pkg::KEY_CR) k = cld_pkg::KEY_LF;
          ring_copy[ed_p[cld_pkg::SLOT_W-1:0]] = k;
          ed_p        = ed_p + 1'b1;
          r.echo_kind = cld_pkg::ECHO_CHAR;
          r.echo_char = k;
          n = ed_p - rd_p;
          if (k == cld_pkg::KEY_LF || k == cld_pkg::KEY_EOF || n == cld_pkg::RING_DEPTH) begin
            cm_p         = ed_p;
            r.line_ready = 1'b1;
          end
        end
      end
    end else begin
      if (rd_p == cm_p) begin
        r.read_status = cld_pkg::RS_EMPTY;
      end else begin
        k = ring_copy[rd_p[cld_pkg::SLOT_W-1:0]];
        if (k == cld_pkg::KEY_EOF) begin
          // end of file is only eaten by the first byte of a read call
          r.read_status = cld_pkg::RS_EOF;
          if (c.first_of_read) rd_p = rd_p + 1'b1;
        end else begin
          rd_p          = rd_p + 1'b1;
          r.read_status = cld_pkg::RS_BYTE;
          r.read_byte   = k;
          r.end_of_line = (k == cld_pkg::KEY_LF);
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, got_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: all values are read at the rising edge, i.e. before any update
  // made at that edge, so a command beat counts when start && !busy held in
  // the cycle just ended and a result beat when done did.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result beat with nothing outstanding, expected none, actual %0h",
                   $time, result);
        end else begin
          want = due_results.pop_front();
          n_checked++;
          check_field("echo_kind",    want.echo_kind,    result.echo_kind);
          check_field("echo_char",    want.echo_char,    result.echo_char);
          check_field("erase_count",  want.erase_count,  result.erase_count);
          check_field("line_ready",   want.line_ready,   result.line_ready);
          check_field("dump_request", want.dump_request, result.dump_request);
          check_field("read_status",  want.read_status,  result.read_status);
          check_field("read_byte",    want.read_byte,    result.read_byte);
          check_field("end_of_line",  want.end_of_line,  result.end_of_line);
          if (want.line_ready) n_lines++;
          if (want.read_status == cld_pkg::RS_BYTE) n_bytes++;
          if (want.read_status == cld_pkg::RS_EOF) n_eofs++;
        end
      end
      if (start && !busy) begin
        if (cmd.action == cld_pkg::ACT_KEY) n_keys++;
        else n_reads++;
        due_results.push_back(line_editor_step(cmd));
      end
    end
  end

  // Watchdog on traffic, not on total time.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no traffic for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, due_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge that took the beat.
  // start is only lowered when a gap is drawn, so back-to-back beats keep it
  // high and never see two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic act, input logic [7:0] key, input logic first);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= '{action: act, key_code: key, first_of_read: first};
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  // the field a command ignores is filled at random
  task automatic key_in(input logic [7:0] key);
    send_cmd(cld_pkg::ACT_KEY, key, 1'($urandom));
  endtask

  task automatic read_one(input logic first);
    send_cmd(cld_pkg::ACT_READ, 8'($urandom), first);
  endtask

  task automatic read_call(input int len);
    read_one(1'b1);
    repeat (len - 1) read_one(1'b0);
  endtask

  // hold off until every outstanding result beat has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_char();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty reads, ignored and special keys on an empty line, single and whole
  // line erase, CR mapping, end-of-line flag, end of file kept then consumed.
  task automatic test_editing_basics();
    read_one(1'b1);
    read_one(1'b0);
    key_in(cld_pkg::KEY_NUL);
    key_in(cld_pkg::KEY_DUMP);
    key_in(cld_pkg::KEY_KILL);
    key_in(cld_pkg::KEY_BS);
    key_in(cld_pkg::KEY_DEL);
    key_in(8'h61);
    key_in(8'hFF);
    key_in(cld_pkg::KEY_BS);
    key_in(8'h80);
    key_in(cld_pkg::KEY_DEL);
    key_in(8'h01);
    key_in(cld_pkg::KEY_KILL);
    key_in(8'h7E);
    key_in(cld_pkg::KEY_CR);
    read_one(1'b1);
    read_one(1'b0);
    read_one(1'b0);
    key_in(cld_pkg::KEY_EOF);
    read_one(1'b0);
    read_one(1'b1);
    read_one(1'b1);
    settle();
  endtask

  // Largest erase (a full ring less one), commit on fill, keys dropped on a
  // full ring, then drain it. Twice, so the slots and pointers wrap.
  task automatic test_ring_extremes();
    repeat (2) begin
      quiet = 1'b1;
      repeat (cld_pkg::RING_DEPTH - 1) key_in(plain_char());
      key_in(cld_pkg::KEY_KILL);
      repeat (cld_pkg::RING_DEPTH) key_in(plain_char());
      quiet = 1'b0;
      key_in(plain_char());
      key_in(cld_pkg::KEY_CR);
      key_in(cld_pkg::KEY_EOF);
      key_in(cld_pkg::KEY_BS);
      key_in(cld_pkg::KEY_KILL);
      quiet = 1'b1;
      read_call(cld_pkg::RING_DEPTH + 1);
      quiet = 1'b0;
      key_in(plain_char());
      read_call(2);
      key_in(cld_pkg::KEY_LF);
      read_call(2);
    end
    settle();
  endtask

  // Mostly typed lines with the odd edit, committed by LF, CR or end of file
  // (or left open), followed by read calls; reads are sometimes skipped so the
  // ring fills. Others are bare read calls; the rest is raw noise over every field.
  task automatic test_random_traffic();
    int target, pick, len;
    target = n_sent + RANDOM_ITEMS;
    while (n_sent < target) begin
      quiet = ($urandom_range(0, 3) == 0);
      pick  = $urandom_range(0, 9);
      if (pick < 6) begin
        len = $urandom_range(0, 20);
        repeat (len) begin
          if ($urandom_range(0, 4) == 0) key_in(8'($urandom));
          else key_in(plain_char());
        end
        case ($urandom_range(0, 3))
          0: key_in(cld_pkg::KEY_LF);
          1: key_in(cld_pkg::KEY_CR);
          2: key_in(cld_pkg::KEY_EOF);
          default: ;
        endcase
        if ($urandom_range(0, 3) != 0) read_call($urandom_range(1, 30));
      end else if (pick < 8) begin
        read_call($urandom_range(1, 30));
      end else begin
        repeat ($urandom_range(1, 8))
          send_cmd(1'($urandom), 8'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 19) == 0) settle();
    end
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    quiet = 1'b0;
    n_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_editing_basics();
    test_ring_extremes();
    test_random_traffic();

    settle();
    repeat (4) @(posedge clk);
    $display("Covered %0d command beats (%0d keystrokes, %0d reads), %0d results checked.",
             n_sent, n_keys, n_reads, n_checked);
    $display("%0d lines committed, %0d bytes returned, %0d end-of-file marks, %0d mismatches.",
             n_lines, n_bytes, n_eofs, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
